### rtl/core/rsr_pkg.sv
// Shared types, codes and default sizes for the reliable stream receiver.
// Used by every module of the block but rsr_ram; depends on nothing.
package rsr_pkg;

    // Default sizes, handed to the top level parameters.
    localparam int MSG_BYTES_DEF     = 128;
    localparam int WINDOW_CHUNKS_DEF = 8;
    localparam int CHUNK_BYTES_DEF   = 8;

    // Packet flag bits.
    localparam logic [7:0] PKT_SYN  = 8'h01;
    localparam logic [7:0] PKT_ACK  = 8'h02;
    localparam logic [7:0] PKT_FIN  = 8'h04;
    localparam logic [7:0] PKT_DATA = 8'h08;

    // Result event codes.
    typedef enum logic [3:0] {
        EV_IGNORED     = 4'd0,
        EV_HS_CORRUPT  = 4'd1,
        EV_SYNACK      = 4'd2,
        EV_ESTABLISHED = 4'd3,
        EV_CORRUPT_ACK = 4'd4,
        EV_FIN         = 4'd5,
        EV_INVALID     = 4'd6,
        EV_DATA        = 4'd7,
        EV_OLD         = 4'd8,
        EV_OUTWINDOW   = 4'd9,
        EV_CLOSED      = 4'd10
    } event_t;

    // Connection phase.
    typedef enum logic [1:0] {
        PH_LISTEN  = 2'd0,
        PH_SYNSEEN = 2'd1,
        PH_EST     = 2'd2,
        PH_CLOSED  = 2'd3
    } phase_t;

    // Back end sequencer states.
    typedef enum logic [2:0] {
        B_IDLE,
        B_DECIDE,
        B_WRITE,
        B_READ,
        B_EMIT
    } back_state_t;

    // One classified packet as it travels from front to back.
    typedef struct packed {
        logic [47:0] src;
        logic [7:0]  seq;
        logic [7:0]  ack;
        logic [7:0]  flags;
        logic [7:0]  len;
        logic [63:0] payload;
        logic [8:0]  seg_end;
        logic        good;
        logic        too_long;
        logic        bad_range;
    } pkt_entry_t;

endpackage

### rtl/core/rsr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package needed.
module rsr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

### rtl/core/rsr_front.sv
// Front end: takes packet beats, checks the checksum and classifies length and range.
// Depends on rsr_pkg.
module rsr_front
    import rsr_pkg::*;
#(
    parameter int MSG_BYTES   = MSG_BYTES_DEF,
    parameter int CHUNK_BYTES = CHUNK_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [47:0] source_addr,
    input  logic [7:0]  pkt_seq,
    input  logic [7:0]  pkt_ack,
    input  logic [7:0]  pkt_flags,
    input  logic [7:0]  pkt_len,
    input  logic [63:0] pkt_payload,
    input  logic [7:0]  pkt_window,
    input  logic [15:0] pkt_checksum,
    input  logic        q_full,
    output logic        q_push,
    output pkt_entry_t  q_data
);

    localparam int SUM_BYTES = (CHUNK_BYTES < 8) ? CHUNK_BYTES : 8;

    logic        fv_reg, fv_next;
    logic [47:0] src_reg;
    logic [7:0]  seq_reg, ack_reg, flags_reg, len_reg, win_reg;
    logic [63:0] pay_reg;
    logic [15:0] csum_reg;
    logic [11:0] sum;
    logic        accept;

    // Input stage holds one beat until the queue takes it.
    assign in_stall = fv_reg && q_full;
    assign accept   = in_valid && !in_stall;
    assign q_push   = fv_reg && !q_full;

    always_comb
    begin
        fv_next = fv_reg;
        if (q_push)
        begin
            fv_next = 1'b0;
        end
        if (accept)
        begin
            fv_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else
        begin
            fv_reg <= fv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            src_reg   <= source_addr;
            seq_reg   <= pkt_seq;
            ack_reg   <= pkt_ack;
            flags_reg <= pkt_flags;
            len_reg   <= pkt_len;
            pay_reg   <= pkt_payload;
            win_reg   <= pkt_window;
            csum_reg  <= pkt_checksum;
        end
    end

    // Header and payload sum; it never exceeds 12 bits, so no fold is needed.
    always_comb
    begin
        sum = 12'(seq_reg) + 12'(ack_reg) + 12'(flags_reg) + 12'(len_reg) + 12'(win_reg);
        for (int i = 0; i < SUM_BYTES; i++)
        begin
            sum = sum + 12'(pay_reg[8*i +: 8]);
        end
    end

    // Classification that does not depend on connection state.
    always_comb
    begin
        q_data.src       = src_reg;
        q_data.seq       = seq_reg;
        q_data.ack       = ack_reg;
        q_data.flags     = flags_reg;
        q_data.len       = len_reg;
        q_data.payload   = pay_reg;
        q_data.seg_end   = 9'(seq_reg) + 9'(len_reg) - 9'd1;
        q_data.good      = (~{4'd0, sum}) == csum_reg;
        q_data.too_long  = 9'(len_reg) > 9'(CHUNK_BYTES);
        q_data.bad_range = (seq_reg == 8'd0) || (9'(seq_reg) > 9'(MSG_BYTES))
                           || (q_data.seg_end > 9'(MSG_BYTES));
    end

endmodule

### rtl/core/rsr_fifo.sv
// Two-entry queue between the front end and the back end.
// Depends on rsr_pkg for the entry type.
module rsr_fifo
    import rsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  pkt_entry_t push_data,
    output logic       full,
    input  logic       pop,
    output logic       not_empty,
    output pkt_entry_t head
);

    pkt_entry_t  mem_reg [2];
    logic        wptr_reg, wptr_next;
    logic        rptr_reg, rptr_next;
    logic [1:0]  cnt_reg, cnt_next;

    assign full      = cnt_reg == 2'd2;
    assign not_empty = cnt_reg != 2'd0;
    assign head      = mem_reg[rptr_reg];

    // Pointer and occupancy update.
    always_comb
    begin
        wptr_next = push ? !wptr_reg : wptr_reg;
        rptr_next = pop ? !rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

endmodule

### rtl/core/rsr_back.sv
// Back end: connection state, reorder bookkeeping, delivery and the result register.
// Depends on rsr_pkg; drives the byte store RAM ports.
module rsr_back
    import rsr_pkg::*;
#(
    parameter int MSG_BYTES     = MSG_BYTES_DEF,
    parameter int WINDOW_CHUNKS = WINDOW_CHUNKS_DEF,
    parameter int CHUNK_BYTES   = CHUNK_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_not_empty,
    input  pkt_entry_t                   q_head,
    output logic                         q_pop,
    output logic                         ram_we,
    output logic [$clog2(MSG_BYTES)-1:0] ram_waddr,
    output logic [7:0]                   ram_wdata,
    output logic [$clog2(MSG_BYTES)-1:0] ram_raddr,
    input  logic [7:0]                   ram_rdata,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [3:0]                   event_res,
    output logic                         reply_valid,
    output logic [7:0]                   reply_flags,
    output logic [7:0]                   reply_ack,
    output logic [6:0]                   reply_window,
    output logic [15:0]                  reply_sum,
    output logic                         byte_valid,
    output logic [7:0]                   out_byte,
    output logic                         last,
    output logic [15:0]                  error_count,
    output logic [7:0]                   delivered_count
);

    localparam int IW  = $clog2(MSG_BYTES);
    localparam int WIN = WINDOW_CHUNKS * CHUNK_BYTES;

    back_state_t          state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic [47:0]          peer_reg, peer_next;
    logic [7:0]           ne_reg, ne_next;
    logic [6:0]           held_reg, held_next;
    logic [MSG_BYTES-1:0] have_reg, have_next;
    logic [15:0]          err_reg, err_next;
    pkt_entry_t           cur_reg, cur_next;
    logic [3:0]           idx_reg, idx_next;

    logic        ov_reg, ov_next;
    event_t      ev_reg, ev_next;
    logic        rv_reg, rv_next;
    logic [7:0]  rf_reg, rf_next, ra_reg, ra_next;
    logic [6:0]  rw_reg, rw_next;
    logic [15:0] rs_reg, rs_next, oerr_reg, oerr_next;
    logic        bv_reg, bv_next, last_reg, last_next;
    logic [7:0]  ob_reg, ob_next, dc_reg, dc_next;

    logic        out_free, emit, e_rv, e_bv, e_last, is_last;
    event_t      e_ev;
    logic [7:0]  e_rf, e_ra, e_ob, e_dc;
    logic [6:0]  e_rw;
    logic [8:0]  wend, bpos;
    logic        in_win, is_old;

    // Held flag of a byte number, false outside 1..MSG_BYTES.
    function automatic logic have_at(input logic [MSG_BYTES-1:0] hv, input logic [8:0] pos);
        logic r;
        r = 1'b0;
        if (pos >= 9'd1 && pos <= 9'(MSG_BYTES))
        begin
            r = hv[IW'(pos - 9'd1)];
        end
        return r;
    endfunction

    // Free window bytes; every held byte at or past next_expected lies in the window.
    function automatic logic [6:0] win_free(input logic [8:0] ne, input logic [6:0] held);
        logic [8:0] we;
        logic [8:0] size;
        logic [6:0] r;
        r = 7'd0;
        if (ne != 9'd0 && ne <= 9'(MSG_BYTES))
        begin
            we = ne + 9'(WIN) - 9'd1;
            if (we > 9'(MSG_BYTES))
            begin
                we = 9'(MSG_BYTES);
            end
            size = we - ne + 9'd1;
            if (9'(held) < size)
            begin
                r = 7'(size - 9'(held));
            end
        end
        return r;
    endfunction

    assign out_free  = !ov_reg || !out_stall;
    assign ram_raddr = IW'(ne_reg - 8'd1);
    assign ram_wdata = cur_reg.payload[8*idx_reg[2:0] +: 8];

    // Window end and segment position relative to next_expected.
    always_comb
    begin
        wend = 9'(ne_reg) + 9'(WIN) - 9'd1;
        if (wend > 9'(MSG_BYTES))
        begin
            wend = 9'(MSG_BYTES);
        end
        in_win  = (9'(cur_reg.seq) <= wend) && (cur_reg.seg_end >= 9'(ne_reg));
        is_old  = cur_reg.seg_end < 9'(ne_reg);
        bpos    = 9'(cur_reg.seq) + 9'(idx_reg);
        is_last = !have_at(have_reg, 9'(ne_reg) + 9'd1);
    end

    // Sequencer: next state, state updates and result generation.
    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        peer_next  = peer_reg;
        ne_next    = ne_reg;
        held_next  = held_reg;
        have_next  = have_reg;
        err_next   = err_reg;
        cur_next   = cur_reg;
        idx_next   = idx_reg;
        q_pop      = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = IW'(bpos - 9'd1);
        emit       = 1'b0;
        e_ev       = EV_IGNORED;
        e_rv       = 1'b0;
        e_rf       = PKT_ACK;
        e_ra       = ne_reg;
        e_rw       = win_free(9'(ne_reg), held_reg);
        e_bv       = 1'b0;
        e_ob       = ram_rdata;
        e_last     = 1'b1;
        e_dc       = ne_reg - 8'd1;

        case (state_reg)
            B_IDLE:
            begin
                if (q_not_empty)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_head;
                    state_next = B_DECIDE;
                end
            end
            B_DECIDE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = B_IDLE;
                    if (phase_reg == PH_CLOSED)
                    begin
                        e_ev = EV_CLOSED;
                    end
                    else if (phase_reg != PH_EST)
                    begin
                        if (!cur_reg.good)
                        begin
                            if (err_reg != 16'hFFFF)
                            begin
                                err_next = err_reg + 16'd1;
                            end
                            e_ev = EV_HS_CORRUPT;
                        end
                        else if ((cur_reg.flags & PKT_SYN) != 8'd0)
                        begin
                            peer_next  = cur_reg.src;
                            phase_next = PH_SYNSEEN;
                            e_ev       = EV_SYNACK;
                            e_rv       = 1'b1;
                            e_rf       = PKT_SYN | PKT_ACK;
                            e_ra       = cur_reg.seq + 8'd1;
                            e_rw       = 7'(WIN);
                        end
                        else if (phase_reg == PH_SYNSEEN && cur_reg.src == peer_reg
                                 && (cur_reg.flags & PKT_ACK) != 8'd0
                                 && cur_reg.ack == 8'd1)
                        begin
                            phase_next = PH_EST;
                            e_ev       = EV_ESTABLISHED;
                        end
                    end
                    else if (cur_reg.src != peer_reg)
                    begin
                        e_ev = EV_IGNORED;
                    end
                    else if (!cur_reg.good)
                    begin
                        if (err_reg != 16'hFFFF)
                        begin
                            err_next = err_reg + 16'd1;
                        end
                        e_ev = EV_CORRUPT_ACK;
                        e_rv = 1'b1;
                    end
                    else if ((cur_reg.flags & PKT_FIN) != 8'd0)
                    begin
                        phase_next = PH_CLOSED;
                        e_ev       = EV_FIN;
                        e_rv       = 1'b1;
                        e_ra       = cur_reg.seq + 8'd1;
                    end
                    else if ((cur_reg.flags & PKT_DATA) == 8'd0 || cur_reg.too_long)
                    begin
                        e_ev = EV_IGNORED;
                    end
                    else if (cur_reg.bad_range)
                    begin
                        e_ev = EV_INVALID;
                        e_rv = 1'b1;
                    end
                    else if (in_win)
                    begin
                        emit       = 1'b0;
                        idx_next   = 4'd0;
                        state_next = (cur_reg.len == 8'd0) ? B_READ : B_WRITE;
                    end
                    else if (is_old)
                    begin
                        e_ev = EV_OLD;
                        e_rv = 1'b1;
                    end
                    else
                    begin
                        e_ev = EV_OUTWINDOW;
                        e_rv = 1'b1;
                    end
                end
            end
            B_WRITE:
            begin
                // One payload byte per cycle into the store, first copy wins.
                if (bpos >= 9'(ne_reg) && bpos <= wend && !have_at(have_reg, bpos))
                begin
                    ram_we                        = 1'b1;
                    have_next[IW'(bpos - 9'd1)]   = 1'b1;
                    held_next                     = held_reg + 7'd1;
                end
                idx_next = idx_reg + 4'd1;
                if (8'(idx_reg) + 8'd1 == cur_reg.len)
                begin
                    state_next = B_READ;
                end
            end
            B_READ:
            begin
                // The read of byte next_expected is issued here.
                if (have_at(have_reg, 9'(ne_reg)))
                begin
                    state_next = B_EMIT;
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    e_ev       = EV_DATA;
                    e_rv       = 1'b1;
                    state_next = B_IDLE;
                end
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    e_ev       = EV_DATA;
                    e_bv       = 1'b1;
                    e_last     = is_last;
                    e_rv       = is_last;
                    e_ra       = ne_reg + 8'd1;
                    e_rw       = win_free(9'(ne_reg) + 9'd1, held_reg - 7'd1);
                    e_dc       = ne_reg;
                    ne_next    = ne_reg + 8'd1;
                    held_next  = held_reg - 7'd1;
                    state_next = is_last ? B_IDLE : B_READ;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Result register.
    always_comb
    begin
        ov_next   = ov_reg && out_stall;
        ev_next   = ev_reg;
        rv_next   = rv_reg;
        rf_next   = rf_reg;
        ra_next   = ra_reg;
        rw_next   = rw_reg;
        rs_next   = rs_reg;
        bv_next   = bv_reg;
        ob_next   = ob_reg;
        last_next = last_reg;
        oerr_next = oerr_reg;
        dc_next   = dc_reg;
        if (emit)
        begin
            ov_next   = 1'b1;
            ev_next   = e_ev;
            rv_next   = e_rv;
            rf_next   = e_rv ? e_rf : 8'd0;
            ra_next   = e_rv ? e_ra : 8'd0;
            rw_next   = e_rv ? e_rw : 7'd0;
            rs_next   = e_rv ? ~(16'(e_ra) + 16'(e_rf) + 16'(e_rw)) : 16'd0;
            bv_next   = e_bv;
            ob_next   = e_bv ? e_ob : 8'd0;
            last_next = e_last;
            oerr_next = err_next;
            dc_next   = e_dc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            phase_reg <= PH_LISTEN;
            peer_reg  <= 48'd0;
            ne_reg    <= 8'd1;
            held_reg  <= 7'd0;
            have_reg  <= '0;
            err_reg   <= 16'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            peer_reg  <= peer_next;
            ne_reg    <= ne_next;
            held_reg  <= held_next;
            have_reg  <= have_next;
            err_reg   <= err_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        idx_reg  <= idx_next;
        ev_reg   <= ev_next;
        rv_reg   <= rv_next;
        rf_reg   <= rf_next;
        ra_reg   <= ra_next;
        rw_reg   <= rw_next;
        rs_reg   <= rs_next;
        bv_reg   <= bv_next;
        ob_reg   <= ob_next;
        last_reg <= last_next;
        oerr_reg <= oerr_next;
        dc_reg   <= dc_next;
    end

    assign out_valid       = ov_reg;
    assign event_res       = ev_reg;
    assign reply_valid     = rv_reg;
    assign reply_flags     = rf_reg;
    assign reply_ack       = ra_reg;
    assign reply_window    = rw_reg;
    assign reply_sum       = rs_reg;
    assign byte_valid      = bv_reg;
    assign out_byte        = ob_reg;
    assign last            = last_reg;
    assign error_count     = oerr_reg;
    assign delivered_count = dc_reg;

endmodule

### rtl/core/reliable_stream_receiver_unit.sv
// Top level of the reliable stream receiver: front end, queue, back end and byte store.
// Depends on rsr_pkg, rsr_front, rsr_fifo, rsr_back and rsr_ram.
//
// Each input beat is one received packet; it produces one or more result beats, the
// final one marked by last. The front end checks the checksum and parks the packet
// in a two-entry queue, so it keeps taking beats while the back end works, until the
// queue is full. The back end takes a packet in B_IDLE and decides it in B_DECIDE,
// which is all that a packet outside the data path needs. For in-window data it then
// writes each payload byte into the byte store (a single-port write RAM) in B_WRITE,
// and reads each delivered byte back through B_READ and B_EMIT; when nothing is
// delivered, B_READ gives the result. No clearing pass is needed after reset.
module reliable_stream_receiver_unit
    import rsr_pkg::*;
#(
    parameter int MSG_BYTES     = MSG_BYTES_DEF,
    parameter int WINDOW_CHUNKS = WINDOW_CHUNKS_DEF,
    parameter int CHUNK_BYTES   = CHUNK_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [47:0] source_addr,
    input  logic [7:0]  pkt_seq,
    input  logic [7:0]  pkt_ack,
    input  logic [7:0]  pkt_flags,
    input  logic [7:0]  pkt_len,
    input  logic [63:0] pkt_payload,
    input  logic [7:0]  pkt_window,
    input  logic [15:0] pkt_checksum,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  event_res,
    output logic        reply_valid,
    output logic [7:0]  reply_flags,
    output logic [7:0]  reply_ack,
    output logic [6:0]  reply_window,
    output logic [15:0] reply_sum,
    output logic        byte_valid,
    output logic [7:0]  out_byte,
    output logic        last,
    output logic [15:0] error_count,
    output logic [7:0]  delivered_count
);

    localparam int IW = $clog2(MSG_BYTES);

    logic             q_full, q_push, q_pop, q_not_empty;
    pkt_entry_t       q_in, q_head;
    logic             ram_we;
    logic [IW-1:0]    ram_waddr, ram_raddr;
    logic [7:0]       ram_wdata, ram_rdata;

    // Checksum and classification of incoming beats.
    rsr_front #(
        .MSG_BYTES   (MSG_BYTES),
        .CHUNK_BYTES (CHUNK_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .source_addr  (source_addr),
        .pkt_seq      (pkt_seq),
        .pkt_ack      (pkt_ack),
        .pkt_flags    (pkt_flags),
        .pkt_len      (pkt_len),
        .pkt_payload  (pkt_payload),
        .pkt_window   (pkt_window),
        .pkt_checksum (pkt_checksum),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_data       (q_in)
    );

    // Decoupling queue.
    rsr_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // Connection state and delivery.
    rsr_back #(
        .MSG_BYTES     (MSG_BYTES),
        .WINDOW_CHUNKS (WINDOW_CHUNKS),
        .CHUNK_BYTES   (CHUNK_BYTES)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_not_empty     (q_not_empty),
        .q_head          (q_head),
        .q_pop           (q_pop),
        .ram_we          (ram_we),
        .ram_waddr       (ram_waddr),
        .ram_wdata       (ram_wdata),
        .ram_raddr       (ram_raddr),
        .ram_rdata       (ram_rdata),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .event_res       (event_res),
        .reply_valid     (reply_valid),
        .reply_flags     (reply_flags),
        .reply_ack       (reply_ack),
        .reply_window    (reply_window),
        .reply_sum       (reply_sum),
        .byte_valid      (byte_valid),
        .out_byte        (out_byte),
        .last            (last),
        .error_count     (error_count),
        .delivered_count (delivered_count)
    );

    // Out-of-order byte store.
    rsr_ram #(
        .WIDTH (8),
        .DEPTH (MSG_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

endmodule
